### sv/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and constants of the bitmap block allocator: operation codes,
// field widths, the sequencer states and the occupancy map control word.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int ADDR_W = 32;
  localparam int REQ_W  = 16;

  localparam logic [ADDR_W-1:0] BASE_RESET = 32'h0010_0000;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_MARK
  } state_t;

  // One step of the occupancy map: rotate by one block, optionally writing
  // the block that leaves the head position.
  typedef struct packed {
    logic shift;
    logic load;
    logic wr_val;
  } map_ctl_t;

endpackage

### sv/bba_map.sv
// ----------------------------------------------------------------------------
// bba_map
// Occupancy bitmap held as a rotating shift register. Block b sits at the
// head position during the b-th step of a pass; a full pass restores order.
// ----------------------------------------------------------------------------
module bba_map #(
  parameter int BLOCK_COUNT = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  bba_pkg::map_ctl_t map_ctl,
  output logic              head_bit
);
  import bba_pkg::*;

  logic [BLOCK_COUNT-1:0] map_r;
  logic [BLOCK_COUNT-1:0] map_nxt;

  assign head_bit = map_r[0];

  always_comb begin
    map_nxt = map_r;
    if (map_ctl.shift) begin
      map_nxt = map_r >> 1;
      map_nxt[BLOCK_COUNT-1] = map_ctl.load ? map_ctl.wr_val : map_r[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_r <= '0;
    end else begin
      map_r <= map_nxt;
    end
  end

endmodule

### sv/bba_seq.sv
// ----------------------------------------------------------------------------
// bba_seq
// Allocation sequencer: takes an item, runs the first-fit search pass and the
// set or clear pass over the rotating bitmap, and strobes out the result.
// ----------------------------------------------------------------------------
module bba_seq #(
  parameter int BLOCK_COUNT = 32,
  parameter int BLOCK_BYTES = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_mode,
  input  logic [bba_pkg::REQ_W-1:0]   in_request_bytes,
  input  logic [bba_pkg::ADDR_W-1:0]  in_release_address,
  input  logic [bba_pkg::ADDR_W-1:0]  base_addr,
  input  logic                        head_bit,
  output bba_pkg::map_ctl_t           map_ctl,
  output logic                        out_valid,
  output logic [bba_pkg::ADDR_W-1:0]  out_granted_address,
  output logic                        out_success
);
  import bba_pkg::*;

  localparam int SPAN = BLOCK_COUNT * BLOCK_BYTES;
  localparam int AW   = $clog2(SPAN + 1);
  localparam int BW   = (AW > REQ_W) ? AW : REQ_W;
  localparam int CW   = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;

  localparam logic [BW-1:0]     BB_W   = BW'(BLOCK_BYTES);
  localparam logic [CW-1:0]     LAST   = CW'(BLOCK_COUNT - 1);
  localparam logic [ADDR_W-1:0] SPAN_A = ADDR_W'(SPAN);

  state_t            state_r, state_nxt;
  logic              mode_r, mode_nxt;
  logic [REQ_W-1:0]  req_r, req_nxt;
  logic [CW-1:0]     blk_r, blk_nxt;
  logic [BW-1:0]     pos_r, pos_nxt;
  logic [BW-1:0]     run_r, run_nxt;
  logic [BW-1:0]     start_off_r, start_off_nxt;
  logic              found_r, found_nxt;
  logic [BW-1:0]     off_r, off_nxt;
  logic [BW-1:0]     done_r, done_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0] granted_r, granted_nxt;
  logic              success_r, success_nxt;

  logic [ADDR_W-1:0] offset;
  logic              in_span;
  logic [BW-1:0]     req_ext;
  logic [BW-1:0]     run_sum;

  assign offset  = in_release_address - base_addr;
  assign in_span = offset < SPAN_A;
  assign req_ext = BW'(req_r);
  assign run_sum = run_r + BB_W;

  assign busy                = (state_r != ST_IDLE);
  assign out_valid           = out_valid_r;
  assign out_granted_address = granted_r;
  assign out_success         = success_r;

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    req_nxt       = req_r;
    blk_nxt       = blk_r;
    pos_nxt       = pos_r;
    run_nxt       = run_r;
    start_off_nxt = start_off_r;
    found_nxt     = found_r;
    off_nxt       = off_r;
    done_nxt      = done_r;
    out_valid_nxt = 1'b0;
    granted_nxt   = granted_r;
    success_nxt   = success_r;
    map_ctl       = '0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          mode_nxt = in_mode;
          req_nxt  = in_request_bytes;
          blk_nxt  = '0;
          if (in_mode == MODE_ALLOC) begin
            if (in_request_bytes == '0) begin
              out_valid_nxt = 1'b1;
              granted_nxt   = '0;
              success_nxt   = 1'b0;
            end else begin
              state_nxt = ST_SEARCH;
              pos_nxt   = '0;
              run_nxt   = '0;
              found_nxt = 1'b0;
            end
          end else if (!in_span) begin
            out_valid_nxt = 1'b1;
            granted_nxt   = '0;
            success_nxt   = 1'b0;
          end else begin
            state_nxt = ST_MARK;
            pos_nxt   = BB_W;
            off_nxt   = offset[BW-1:0];
            done_nxt  = '0;
          end
        end
      end

      ST_SEARCH: begin
        map_ctl.shift = 1'b1;
        if (!found_r) begin
          if (head_bit) begin
            run_nxt = '0;
          end else begin
            if (run_r == '0) begin
              start_off_nxt = pos_r;
            end
            run_nxt = run_sum;
            // The run is long enough once its byte span covers the request.
            if (run_sum >= req_ext) begin
              found_nxt = 1'b1;
            end
          end
        end
        blk_nxt = blk_r + 1'b1;
        pos_nxt = pos_r + BB_W;
        if (blk_r == LAST) begin
          blk_nxt = '0;
          if (found_nxt) begin
            state_nxt = ST_MARK;
            pos_nxt   = BB_W;
            off_nxt   = start_off_nxt;
            done_nxt  = '0;
          end else begin
            state_nxt     = ST_IDLE;
            out_valid_nxt = 1'b1;
            granted_nxt   = '0;
            success_nxt   = 1'b0;
          end
        end
      end

      ST_MARK: begin
        map_ctl.shift = 1'b1;
        // pos_r is the end offset of the head block, so the block lies at or
        // after the first block of the run once it exceeds the run offset.
        if ((pos_r > off_r) && (done_r < req_ext)) begin
          map_ctl.load   = 1'b1;
          map_ctl.wr_val = (mode_r == MODE_ALLOC);
          done_nxt       = done_r + BB_W;
        end
        blk_nxt = blk_r + 1'b1;
        pos_nxt = pos_r + BB_W;
        if (blk_r == LAST) begin
          blk_nxt       = '0;
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          success_nxt   = 1'b1;
          granted_nxt   = (mode_r == MODE_ALLOC) ?
                          base_addr + ADDR_W'(start_off_r) : '0;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      blk_r       <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      blk_r       <= blk_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r      <= mode_nxt;
    req_r       <= req_nxt;
    pos_r       <= pos_nxt;
    run_r       <= run_nxt;
    start_off_r <= start_off_nxt;
    off_r       <= off_nxt;
    done_r      <= done_nxt;
    granted_r   <= granted_nxt;
    success_r   <= success_nxt;
  end

`ifndef ASSERT_OFF
  a_valid_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(busy || start))
    else $error("result strobe without a preceding item");

  a_end_of_pass_reports: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(busy) && $past(rst_n)) |-> out_valid_r)
    else $error("pass ended without a result strobe");

  a_alloc_mark_found: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MARK && mode_r == MODE_ALLOC) |-> found_r)
    else $error("marking an allocation that found no run");

  a_granted_means_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && granted_r != '0) |-> success_r)
    else $error("nonzero address reported with failure");
`endif

endmodule

### sv/bitmap_block_allocator_top.sv
// ----------------------------------------------------------------------------
// bitmap_block_allocator_top
// First-fit block allocator over a bitmap of fixed-size heap blocks.
// ----------------------------------------------------------------------------
// Usage: drive in_mode, in_request_bytes and in_release_address with start
// high; the item is taken at an edge where busy is low. Allocation (mode 0)
// rounds the size up to whole blocks, takes the first free run from block 0
// and returns its byte address; a free (mode 1) clears the size, rounded up
// to whole blocks, from the block holding the given address.
// Each item yields one result, shown for one cycle with out_valid high.
// The result cannot be held off; the next item may start in that cycle.
// A pass visits all HEAP_BYTES / BLOCK_BYTES blocks: the bitmap rotates
// one block per cycle through a single head bit while a pass runs. An
// allocation takes a search pass and a marking pass; a free or a failed
// search takes one pass. A zero-size allocation or a free outside the heap
// answers without a pass. Reset clears the bitmap (all blocks free) and
// loads the heap base with 0x0010_0000. The cfg_ channel is always ready;
// the user writes it only while idle, which the block does not enforce.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_top #(
  parameter int HEAP_BYTES  = 2048,
  parameter int BLOCK_BYTES = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_mode,
  input  logic [bba_pkg::REQ_W-1:0]   in_request_bytes,
  input  logic [bba_pkg::ADDR_W-1:0]  in_release_address,
  output logic                        out_valid,
  output logic [bba_pkg::ADDR_W-1:0]  out_granted_address,
  output logic                        out_success,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [bba_pkg::ADDR_W-1:0]  cfg_heap_base_address
);
  import bba_pkg::*;

  localparam int BLOCK_COUNT = HEAP_BYTES / BLOCK_BYTES;

  logic [ADDR_W-1:0] base_r;
  logic [ADDR_W-1:0] base_nxt;
  map_ctl_t          map_ctl;
  logic              head_bit;

  assign cfg_ready = 1'b1;
  assign base_nxt  = (cfg_valid && cfg_ready) ? cfg_heap_base_address : base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= BASE_RESET;
    end else begin
      base_r <= base_nxt;
    end
  end

  bba_map #(
    .BLOCK_COUNT(BLOCK_COUNT)
  ) u_map (
    .clk      (clk),
    .rst_n    (rst_n),
    .map_ctl  (map_ctl),
    .head_bit (head_bit)
  );

  bba_seq #(
    .BLOCK_COUNT(BLOCK_COUNT),
    .BLOCK_BYTES(BLOCK_BYTES)
  ) u_seq (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_mode             (in_mode),
    .in_request_bytes    (in_request_bytes),
    .in_release_address  (in_release_address),
    .base_addr           (base_r),
    .head_bit            (head_bit),
    .map_ctl             (map_ctl),
    .out_valid           (out_valid),
    .out_granted_address (out_granted_address),
    .out_success         (out_success)
  );

endmodule

### tb/bitmap_block_allocator_checker.sv
// ----------------------------------------------------------------------------
// bitmap_block_allocator_checker
// Watches the item, result and register channels of the block allocator,
// keeps its own occupancy map and heap base, predicts each result and
// compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_checker #(
  parameter int HEAP_BYTES  = 2048,
  parameter int BLOCK_BYTES = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        busy,
  input  logic                        in_mode,
  input  logic [bba_pkg::REQ_W-1:0]   in_request_bytes,
  input  logic [bba_pkg::ADDR_W-1:0]  in_release_address,
  input  logic                        out_valid,
  input  logic [bba_pkg::ADDR_W-1:0]  out_granted_address,
  input  logic                        out_success,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [bba_pkg::ADDR_W-1:0]  cfg_heap_base_address,
  output int                          error_count,
  output int                          pending
);
  import bba_pkg::*;

  localparam int BLOCKS = HEAP_BYTES / BLOCK_BYTES;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              ok;
  } grant_t;

  logic [BLOCKS-1:0] occupied;
  logic [ADDR_W-1:0] base_addr;
  grant_t            grants_due[$];

  initial begin
    error_count = 0;
    pending     = 0;
    occupied    = '0;
    base_addr   = BASE_RESET;
  end

  // Applies one item to the local occupancy map and returns what the block
  // should answer.
  function automatic grant_t serve_request(logic mode, logic [REQ_W-1:0] req,
                                           logic [ADDR_W-1:0] rel);
    int unsigned       need;
    int unsigned       run;
    int unsigned       first;
    bit                found;
    logic [ADDR_W-1:0] offset;
    grant_t            g;
    g     = '{addr: '0, ok: 1'b0};
    need  = (32'(req) + BLOCK_BYTES - 1) / BLOCK_BYTES;
    run   = 0;
    first = 0;
    found = 1'b0;
    if (mode == MODE_ALLOC) begin
      if (need != 0 && need <= BLOCKS) begin
        for (int blk = 0; blk < BLOCKS && !found; blk++) begin
          if (occupied[blk]) begin
            run = 0;
          end else begin
            if (run == 0) first = blk;
            run++;
            if (run == need) found = 1'b1;
          end
        end
        if (found) begin
          for (int blk = 0; blk < BLOCKS; blk++)
            if (blk >= first && blk < first + need) occupied[blk] = 1'b1;
          g.addr = base_addr + ADDR_W'(first * BLOCK_BYTES);
          g.ok   = 1'b1;
        end
      end
    end else begin
      // The offset wraps, so addresses below the base land far outside.
      offset = rel - base_addr;
      if (offset < ADDR_W'(BLOCKS * BLOCK_BYTES)) begin
        first = offset / BLOCK_BYTES;
        for (int unsigned k = 0; k < need && first + k < BLOCKS; k++)
          occupied[first + k] = 1'b0;
        g.ok = 1'b1;
      end
    end
    return g;
  endfunction

  task automatic note_mismatch(string what, logic [ADDR_W-1:0] exp_val,
                               logic [ADDR_W-1:0] act_val);
    error_count++;
    if (error_count <= 10)
      $display("mismatch at %0t: %s expected 0x%08h got 0x%08h",
               $realtime, what, exp_val, act_val);
  endtask

  always @(posedge clk) begin : watch
    grant_t due;
    if (!rst_n) begin
      occupied  = '0;
      base_addr = BASE_RESET;
      grants_due.delete();
    end else begin
      if (out_valid) begin
        if (grants_due.size() == 0) begin
          note_mismatch("unexpected result, granted_address", '0, out_granted_address);
        end else begin
          due = grants_due.pop_front();
          if (out_granted_address !== due.addr)
            note_mismatch("granted_address", due.addr, out_granted_address);
          if (out_success !== due.ok)
            note_mismatch("success", ADDR_W'(due.ok), ADDR_W'(out_success));
        end
      end
      if (start && !busy)
        grants_due.push_back(serve_request(in_mode, in_request_bytes, in_release_address));
      if (cfg_valid && cfg_ready)
        base_addr = cfg_heap_base_address;
    end
    pending = grants_due.size();
  end

endmodule

### tb/bitmap_block_allocator_top_tb.sv
// ----------------------------------------------------------------------------
// bitmap_block_allocator_top_tb
// Drives the block allocator with a directed opening sequence and then
// random allocate and free items under several heap bases and sender idle
// rates; the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_top_tb;
  import bba_pkg::*;

  localparam int HEAP_BYTES   = 2048;
  localparam int BLOCK_BYTES  = 64;
  localparam int BLOCKS       = HEAP_BYTES / BLOCK_BYTES;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 100;
  localparam int STALL_LIMIT  = 4000;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic              in_mode;
  logic [REQ_W-1:0]  in_request_bytes;
  logic [ADDR_W-1:0] in_release_address;
  logic              out_valid;
  logic [ADDR_W-1:0] out_granted_address;
  logic              out_success;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [ADDR_W-1:0] cfg_heap_base_address;

  int                error_count;
  int                pending;
  int                sender_idle_pct;
  int                quiet_cycles;

  bitmap_block_allocator_top #(
    .HEAP_BYTES (HEAP_BYTES),
    .BLOCK_BYTES(BLOCK_BYTES)
  ) DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_mode              (in_mode),
    .in_request_bytes     (in_request_bytes),
    .in_release_address   (in_release_address),
    .out_valid            (out_valid),
    .out_granted_address  (out_granted_address),
    .out_success          (out_success),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_heap_base_address(cfg_heap_base_address)
  );

  bitmap_block_allocator_checker #(
    .HEAP_BYTES (HEAP_BYTES),
    .BLOCK_BYTES(BLOCK_BYTES)
  ) u_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_mode              (in_mode),
    .in_request_bytes     (in_request_bytes),
    .in_release_address   (in_release_address),
    .out_valid            (out_valid),
    .out_granted_address  (out_granted_address),
    .out_success          (out_success),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_heap_base_address(cfg_heap_base_address),
    .error_count          (error_count),
    .pending              (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Any handshake counts as progress; a long silence means the block hung.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic drive_item(logic mode, logic [REQ_W-1:0] req, logic [ADDR_W-1:0] rel);
    @(negedge clk);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start              = 1'b0;
      in_mode            = 1'($urandom());
      in_request_bytes   = REQ_W'($urandom());
      in_release_address = $urandom();
      @(negedge clk);
    end
    start              = 1'b1;
    in_mode            = mode;
    in_request_bytes   = req;
    in_release_address = rel;
    do @(posedge clk); while (busy);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start = 1'b0;
    while (pending != 0 || busy) @(negedge clk);
  endtask

  task automatic write_heap_base(logic [ADDR_W-1:0] value);
    wait_drained();
    cfg_valid             = 1'b1;
    cfg_heap_base_address = value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid             = 1'b0;
    cfg_heap_base_address = $urandom();
  endtask

  // Mostly allocations of modest size and frees inside the heap, so the map
  // keeps filling and draining; the rest is odd sizes and stray addresses.
  task automatic random_item(logic [ADDR_W-1:0] base);
    int                pick;
    int                sel;
    logic [REQ_W-1:0]  req;
    logic [ADDR_W-1:0] rel;
    pick = $urandom_range(0, 99);
    sel  = $urandom_range(0, 99);
    rel  = $urandom();
    if (pick < 55) begin
      if (sel < 70)      req = REQ_W'($urandom_range(1, 256));
      else if (sel < 88) req = REQ_W'($urandom_range(257, HEAP_BYTES));
      else if (sel < 94) req = '0;
      else               req = REQ_W'($urandom());
      drive_item(MODE_ALLOC, req, rel);
    end else begin
      if (sel < 80)      req = REQ_W'($urandom_range(1, 512));
      else if (sel < 90) req = '0;
      else               req = REQ_W'($urandom());
      if (pick < 92) begin
        rel = base + ADDR_W'($urandom_range(0, HEAP_BYTES - 1));
      end else begin
        case ($urandom_range(0, 2))
          0:       rel = base - ADDR_W'($urandom_range(1, BLOCK_BYTES));
          1:       rel = base + ADDR_W'(HEAP_BYTES + $urandom_range(0, BLOCK_BYTES));
          default: rel = $urandom();
        endcase
      end
      drive_item(MODE_FREE, req, rel);
    end
  endtask

  initial begin : stimulus
    logic [ADDR_W-1:0] bases [PHASES];
    int                idle_pct [PHASES];
    logic [ADDR_W-1:0] b;
    bases    = '{BASE_RESET, 32'h0000_0000, 32'hFFFF_FFC0, 32'hFFFF_FFFF,
                 32'h0, BASE_RESET};
    idle_pct = '{0, 88, 0, 11, 88, 0};
    bases[4] = $urandom();

    rst_n                 = 1'b0;
    start                 = 1'b0;
    in_mode               = MODE_ALLOC;
    in_request_bytes      = '0;
    in_release_address    = '0;
    cfg_valid             = 1'b0;
    cfg_heap_base_address = '0;
    sender_idle_pct       = 0;
    quiet_cycles          = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed opening at the reset base.
    b = BASE_RESET;
    drive_item(MODE_ALLOC, 16'd0, $urandom());
    drive_item(MODE_ALLOC, 16'd1, $urandom());
    drive_item(MODE_ALLOC, 16'd64, $urandom());
    drive_item(MODE_ALLOC, 16'd65, $urandom());
    drive_item(MODE_ALLOC, 16'hFFFF, $urandom());
    drive_item(MODE_ALLOC, 16'(HEAP_BYTES), $urandom());
    drive_item(MODE_FREE, 16'd64, b + 64);
    drive_item(MODE_ALLOC, 16'd64, $urandom());
    // An unaligned free selects the block that holds the address.
    drive_item(MODE_FREE, 16'd100, b + 130);
    drive_item(MODE_FREE, 16'd64, b - 1);
    drive_item(MODE_FREE, 16'd64, b + HEAP_BYTES);
    drive_item(MODE_FREE, 16'hFFFF, b + HEAP_BYTES - 1);
    drive_item(MODE_FREE, 16'd0, b + 1024);
    drive_item(MODE_FREE, 16'd64, b + 1024);
    drive_item(MODE_FREE, 16'(HEAP_BYTES), b);
    drive_item(MODE_ALLOC, 16'(HEAP_BYTES), 32'hFFFF_FFFF);
    drive_item(MODE_ALLOC, 16'd1, 32'h0000_0000);
    drive_item(MODE_FREE, 16'hFFFF, b);
    drive_item(MODE_FREE, 16'hFFFF, 32'hFFFF_FFFF);
    drive_item(MODE_ALLOC, 16'(HEAP_BYTES - BLOCK_BYTES), $urandom());
    drive_item(MODE_ALLOC, 16'd128, $urandom());
    drive_item(MODE_FREE, 16'(HEAP_BYTES), b);

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph != 0) write_heap_base(bases[ph]);
      sender_idle_pct = idle_pct[ph];
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == PHASE_ITEMS / 2) wait_drained();
        random_item(bases[ph]);
      end
    end

    wait_drained();
    repeat (2 * BLOCKS + 8) @(posedge clk);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
